/* rtl/wbps_pkg.sv */
// ----------------------------------------------------------------------------
// wbps_pkg
// shared types and constants for the wildcard byte pattern scanner
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int PATTERN_REG_POS = 16;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_INDEX_W     = 3;
  localparam int ADDR_W          = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_MODE      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_POSITION_KINDS  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDRESS    = 3'd5;

  localparam logic [1:0] KIND_EXACT = 2'd0;
  localparam logic [1:0] KIND_LOW   = 2'd1;
  localparam logic [1:0] KIND_HIGH  = 2'd2;
  localparam logic [1:0] KIND_WILD  = 2'd3;

  localparam logic [3:0] NIBBLE_ZERO = 4'h0;
  localparam logic [7:0] TERMINATOR  = 8'h00;

  typedef struct packed {
    logic                        match_mode;
    logic [4:0]                  pattern_length;
    logic [8*PATTERN_REG_POS-1:0] pattern_bytes;
    logic [2*PATTERN_REG_POS-1:0] position_kinds;
    logic [ADDR_W-1:0]           base_address;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [ADDR_W-1:0] seen;
  } win_stage_t;

endpackage

/* rtl/wildcard_byte_pattern_scanner_top.sv */
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_top
// streams a region byte by byte and reports the first window matching the
// configured wildcard byte pattern or zero terminated string
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one region byte per word, s_tlast on the region's final byte.
//   m_* carries one result per region: m_tuser high with the match address,
//   or m_tuser low and address zero at the last byte when nothing matched.
//   cfg_write/cfg_index/cfg_data load registers 0..5 while the stream is idle.
// result path: a byte that completes a match is first registered into the window
//   and stage register, then its compare result goes into the output register.
// throughput: one byte per cycle unless a result is blocked at the output;
//   all positions compare in parallel against the shift window in one pass.
// reset: clears configuration to defaults, the region counters and both
//   valid flags; the window contents are masked by the fill count.
// stall: while m_tready is low a pending result stays in the output register;
//   bytes that produce no result keep flowing, and the input side stops only
//   when a second result would need the occupied register.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_top #(
  parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // data_byte
  input  logic                              s_tlast,   // last_byte
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [31:0]                       m_tdata,   // match_address
  output logic                              m_tuser,   // found
  input  logic                              cfg_write,
  input  logic [wbps_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import wbps_pkg::*;

  localparam int DEPTH = PATTERN_MAX + 1;
  localparam int CW = $clog2(DEPTH + 1);

  cfg_t              cfg;
  win_stage_t        stage;
  logic [7:0]        window [DEPTH];
  logic [CW-1:0]     stage_fill;
  logic              hit;
  logic [ADDR_W-1:0] hit_address;
  logic              already_found;
  logic              emit;
  logic              consume;
  logic              accept;

  wbps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wbps_window #(.PATTERN_MAX(PATTERN_MAX)) u_window (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .consume    (consume),
    .data_byte  (s_tdata),
    .last_byte  (s_tlast),
    .window     (window),
    .stage_fill (stage_fill),
    .stage      (stage)
  );

  wbps_match #(.PATTERN_MAX(PATTERN_MAX)) u_match (
    .cfg           (cfg),
    .window        (window),
    .fill          (stage_fill),
    .seen          (stage.seen),
    .hit           (hit),
    .match_address (hit_address)
  );

  assign emit     = stage.valid && !already_found && (hit || stage.last);
  assign consume  = stage.valid && (!emit || !m_tvalid || m_tready);
  assign s_tready = !stage.valid || consume;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      already_found <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (consume) begin
        if (stage.last) begin
          already_found <= 1'b0;
        end else if (emit) begin
          already_found <= 1'b1;
        end
      end
      if (consume && emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume && emit) begin
      m_tuser <= hit;
      m_tdata <= hit ? hit_address : '0;
    end
  end

  // no result while a match of the current region is already out
  assert property (@(posedge clk) disable iff (rst)
    already_found && stage.valid |-> !emit)
    else $error("second result in one region");

  // region end always clears the found flag
  assert property (@(posedge clk) disable iff (rst)
    consume && stage.last |=> !already_found)
    else $error("found flag survived region end");

  // a not-found result carries address zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("nonzero address on miss");

  // an accepted byte always lands in the stage register
  assert property (@(posedge clk) disable iff (rst)
    accept |=> stage.valid)
    else $error("accepted byte lost");

endmodule

/* rtl/wbps_cfg.sv */
// ----------------------------------------------------------------------------
// wbps_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
module wbps_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [wbps_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_data,
  output wbps_pkg::cfg_t                    cfg
);
  import wbps_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_mode     <= 1'b0;
      cfg.pattern_length <= 5'd1;
      cfg.pattern_bytes  <= '0;
      cfg.position_kinds <= '0;
      cfg.base_address   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MATCH_MODE:     cfg.match_mode <= cfg_data[0];
        CFG_PATTERN_LENGTH: cfg.pattern_length <= cfg_data[4:0];
        CFG_PATTERN_LOW:    cfg.pattern_bytes[63:0] <= cfg_data;
        CFG_PATTERN_HIGH:   cfg.pattern_bytes[127:64] <= cfg_data;
        CFG_POSITION_KINDS: cfg.position_kinds <= cfg_data[31:0];
        CFG_BASE_ADDRESS:   cfg.base_address <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/wbps_window.sv */
// ----------------------------------------------------------------------------
// wbps_window
// byte shift window, region counters and input stage register
// ----------------------------------------------------------------------------
module wbps_window #(
  parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
  localparam int DEPTH = PATTERN_MAX + 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic                    consume,
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  output logic [7:0]              window [DEPTH],
  output logic [CW-1:0]           stage_fill,
  output wbps_pkg::win_stage_t    stage
);
  import wbps_pkg::*;

  logic [ADDR_W-1:0] seen;
  logic [ADDR_W-1:0] seen_next;
  logic [CW-1:0]     fill;
  logic [CW-1:0]     fill_next;

  assign seen_next = seen + 32'd1;
  assign fill_next = (fill == CW'(DEPTH)) ? fill : fill + CW'(1);

  always_ff @(posedge clk) begin
    if (accept) begin
      window[0] <= data_byte;
      for (int j = 1; j < DEPTH; j++) begin
        window[j] <= window[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen        <= '0;
      fill        <= '0;
      stage.valid <= 1'b0;
    end else begin
      if (accept) begin
        seen        <= last_byte ? '0 : seen_next;
        fill        <= last_byte ? '0 : fill_next;
        stage.valid <= 1'b1;
        stage.last  <= last_byte;
        stage.seen  <= seen_next;
        stage_fill  <= fill_next;
      end else if (consume) begin
        stage.valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/wbps_match.sv */
// ----------------------------------------------------------------------------
// wbps_match
// parallel compare of all pattern positions against the window
// ----------------------------------------------------------------------------
module wbps_match #(
  parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
  localparam int DEPTH = PATTERN_MAX + 1,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int IW = $clog2(DEPTH)
) (
  input  wbps_pkg::cfg_t                cfg,
  input  logic [7:0]                    window [DEPTH],
  input  logic [CW-1:0]                 fill,
  input  logic [wbps_pkg::ADDR_W-1:0]   seen,
  output logic                          hit,
  output logic [wbps_pkg::ADDR_W-1:0]   match_address
);
  import wbps_pkg::*;

  logic [CW-1:0]          n;
  logic [CW-1:0]          span;
  logic [PATTERN_MAX-1:0] pos_ok;

  always_comb begin
    if (32'(cfg.pattern_length) > PATTERN_MAX) begin
      n = CW'(PATTERN_MAX);
    end else begin
      n = CW'(cfg.pattern_length);
    end
  end

  assign span = n + CW'(cfg.match_mode);

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pos
    logic [7:0]    v;
    logic [1:0]    k;
    logic [7:0]    b;
    logic [CW-1:0] idx;
    logic          active;
    logic          is_last;
    logic          byte_ok;

    if (i < PATTERN_REG_POS) begin : g_reg
      assign v = cfg.pattern_bytes[8*i +: 8];
      assign k = cfg.position_kinds[2*i +: 2];
    end else begin : g_zero
      assign v = '0;
      assign k = KIND_EXACT;
    end

    assign idx     = span - CW'(i + 1);
    assign b       = (idx < CW'(DEPTH)) ? window[idx[IW-1:0]] : '0;
    assign active  = CW'(i) < n;
    assign is_last = CW'(i) == (n - CW'(1));

    always_comb begin
      if (!is_last && (k == KIND_WILD || v == '0)) begin
        byte_ok = 1'b1;
      end else begin
        case (k)
          KIND_EXACT: byte_ok = (b == v);
          KIND_LOW:   byte_ok = ({NIBBLE_ZERO, b[3:0]} == v);
          KIND_HIGH:  byte_ok = ({NIBBLE_ZERO, b[7:4]} == v);
          default:    byte_ok = ({NIBBLE_ZERO, b[3:0]} == v) && ({NIBBLE_ZERO, b[7:4]} == v);
        endcase
      end
    end

    assign pos_ok[i] = !active || (cfg.match_mode ? (b == v) : byte_ok);
  end

  assign hit = (n != '0) && (fill >= span) && (&pos_ok)
               && (!cfg.match_mode || window[0] == TERMINATOR);

  assign match_address = cfg.base_address + (seen - ADDR_W'(span));

endmodule

/* sim/wildcard_byte_pattern_scanner_top_tb.sv */
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_top_tb
// self-checking bench for the wildcard byte pattern scanner: a scoreboard
// mirrors the shift window and the first-match rule for byte and string
// modes, predicts one result per region and checks every output word in order
// against it while both stream sides idle and stall at random
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wbps_pkg::*;

  localparam int WINDOW_DEPTH = PATTERN_MAX_DEF + 1;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } scan_result_t;

  class scan_scoreboard;
    bit                  mode;
    bit [4:0]            plen = 5'd1;
    bit [63:0]           plow;
    bit [63:0]           phigh;
    bit [31:0]           kinds;
    bit [ADDR_W-1:0]     base;
    bit [7:0]            recent_bytes [WINDOW_DEPTH];
    bit [ADDR_W-1:0]     seen;
    bit                  done;
    int unsigned         fill;
    scan_result_t        pending_results [$];
    int                  errors;

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_MATCH_MODE:     mode  = d[0];
        CFG_PATTERN_LENGTH: plen  = d[4:0];
        CFG_PATTERN_LOW:    plow  = d;
        CFG_PATTERN_HIGH:   phigh = d;
        CFG_POSITION_KINDS: kinds = d[31:0];
        CFG_BASE_ADDRESS:   base  = d[ADDR_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [7:0] value_at(int i);
      return (i < 8) ? plow[8*i +: 8] : phigh[8*(i-8) +: 8];
    endfunction

    function bit [1:0] kind_at(int i);
      return kinds[2*i +: 2];
    endfunction

    function int unsigned eff_len();
      return (plen > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : plen;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function bit byte_hit(int n);
      bit [7:0] b;
      bit [7:0] v;
      bit [1:0] k;
      for (int i = 0; i < n; i++) begin
        b = recent_bytes[n-1-i];
        v = value_at(i);
        k = kind_at(i);
        if (i != n - 1 && (k == KIND_WILD || v == 8'h00)) continue;
        if ((k == KIND_LOW || k == KIND_WILD) && {4'h0, b[3:0]} != v) return 1'b0;
        if ((k == KIND_HIGH || k == KIND_WILD) && {4'h0, b[7:4]} != v) return 1'b0;
        if (k == KIND_EXACT && b != v) return 1'b0;
      end
      return 1'b1;
    endfunction

    function bit string_hit(int n);
      for (int i = 0; i < n; i++)
        if (recent_bytes[n-i] != value_at(i)) return 1'b0;
      return recent_bytes[0] == TERMINATOR;
    endfunction

    function void note_byte(bit [7:0] b, bit last);
      int unsigned  n;
      int unsigned  span;
      scan_result_t r;
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
      recent_bytes[0] = b;
      seen = seen + 1;
      if (fill < WINDOW_DEPTH) fill++;
      n = eff_len();
      span = mode ? n + 1 : n;
      if (!done && n != 0 && fill >= span) begin
        if (mode ? string_hit(n) : byte_hit(n)) begin
          done = 1'b1;
          r.found = 1'b1;
          r.addr = base + (seen - span);
          pending_results.insert(pending_results.size(), r);
        end
      end
      if (last) begin
        if (!done) begin
          r.found = 1'b0;
          r.addr = '0;
          pending_results.insert(pending_results.size(), r);
        end
        seen = '0;
        fill = 0;
        done = 1'b0;
      end
    endfunction

    task report(string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic found, logic [ADDR_W-1:0] addr);
      scan_result_t e;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected word found=%0b addr=%h", found, addr));
        return;
      end
      e = pending_results.pop_front();
      if (found !== e.found)
        report($sformatf("found %b, expected %b", found, e.found));
      if (addr !== e.addr)
        report($sformatf("match address %h, expected %h", addr, e.addr));
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [7:0]             s_tdata;
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [31:0]            m_tdata;
  logic                   m_tuser;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  bit steady;
  bit hold_request;
  bit short_regions;

  scan_scoreboard sb = new();

  wildcard_byte_pattern_scanner_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    end
  end

  // receiver, with one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request <= 1'b0;
        m_tready <= 1'b0;
        repeat (200) @(negedge clk);
      end
      m_tready <= steady || ($urandom_range(99) >= 18);
    end
  end

  task automatic send_word(bit [7:0] b, bit last);
    if (!steady && $urandom_range(99) < 18) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // wait until every result is in and the pipeline has drained
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic bit [7:0] noise();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 8'($urandom_range(255));
    if (r < 85) return sb.value_at($urandom_range(15));
    return TERMINATOR;
  endfunction

  task automatic new_setting();
    bit [63:0] lo;
    bit [63:0] hi;
    bit [31:0] kd;
    bit [7:0]  v;
    bit [1:0]  k;
    bit [4:0]  len;
    bit [31:0] base;
    int        r;
    r = $urandom_range(99);
    if (r < 6) len = 5'd0;
    else if (r < 14) len = 5'($urandom_range(17, 31));
    else if (r < 30) len = 5'd16;
    else len = 5'($urandom_range(1, 15));
    for (int i = 0; i < 16; i++) begin
      k = 2'($urandom_range(3));
      r = $urandom_range(99);
      if (k == KIND_EXACT) v = (r < 15) ? 8'h00 : 8'($urandom_range(255));
      else v = (r < 85) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
      kd[2*i +: 2] = k;
      if (i < 8) lo[8*i +: 8] = v;
      else hi[8*(i-8) +: 8] = v;
    end
    base = ($urandom_range(99) < 20) ? 32'hFFFF_FFFF - $urandom_range(20) : $urandom();
    write_reg(CFG_MATCH_MODE, 64'($urandom_range(99) < 35));
    write_reg(CFG_PATTERN_LENGTH, 64'(len));
    write_reg(CFG_PATTERN_LOW, lo);
    write_reg(CFG_PATTERN_HIGH, hi);
    write_reg(CFG_POSITION_KINDS, 64'(kd));
    write_reg(CFG_BASE_ADDRESS, 64'(base));
  endtask

  // noise, optionally a planted match (maybe with one flipped bit), noise
  task automatic send_region(int pre, bit plant, bit corrupt, int post, output int sent);
    bit [7:0] q [$];
    bit [7:0] v;
    bit [1:0] k;
    bit [7:0] b;
    int       n;
    int       start;
    int       idx;
    repeat (pre) q.insert(q.size(), noise());
    n = sb.eff_len();
    start = q.size();
    if (plant && n != 0) begin
      for (int i = 0; i < n; i++) begin
        v = sb.value_at(i);
        k = sb.kind_at(i);
        if (sb.mode) b = v;
        else if (i != n - 1 && (v == 8'h00 || k == KIND_WILD)) b = 8'($urandom_range(255));
        else begin
          case (k)
            KIND_EXACT: b = v;
            KIND_LOW:   b = {4'($urandom_range(15)), v[3:0]};
            KIND_HIGH:  b = {v[3:0], 4'($urandom_range(15))};
            default:    b = {v[3:0], v[3:0]};
          endcase
        end
        q.insert(q.size(), b);
      end
      if (sb.mode) q.insert(q.size(), TERMINATOR);
      if (corrupt) begin
        idx = start + $urandom_range(q.size() - 1 - start);
        q[idx] = q[idx] ^ (8'h01 << $urandom_range(7));
      end
    end
    repeat (post) q.insert(q.size(), noise());
    if (q.size() == 0) q.insert(q.size(), noise());
    foreach (q[i]) send_word(q[i], i == q.size() - 1);
    sent = q.size();
  endtask

  initial begin
    int sent;
    int phase_bytes;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset setting: one exact zero byte
    send_word(8'h00, 1'b0);
    send_word(8'h5A, 1'b1);
    send_word(8'h5A, 1'b1);
    settle();

    // zero length never matches
    write_reg(CFG_PATTERN_LENGTH, 64'd0);
    send_word(8'h00, 1'b1);
    settle();

    // one position of each kind, address wraps past the top
    write_reg(CFG_PATTERN_LENGTH, 64'd4);
    write_reg(CFG_PATTERN_LOW, 64'h0000_0000_070C_03A5);
    write_reg(CFG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_POSITION_KINDS, 64'hFFFF_FFE4);
    write_reg(CFG_BASE_ADDRESS, 64'hFFFF_FFFF);
    send_word(8'h11, 1'b0);
    send_word(8'hA5, 1'b0);
    send_word(8'hF3, 1'b0);
    send_word(8'hC0, 1'b0);
    send_word(8'h77, 1'b0);
    send_word(8'h00, 1'b1);
    // match cut off by the region end
    send_word(8'hA5, 1'b0);
    send_word(8'hF3, 1'b0);
    send_word(8'hC0, 1'b1);
    settle();

    // string mode with terminator, then without
    write_reg(CFG_MATCH_MODE, 64'd1);
    write_reg(CFG_PATTERN_LENGTH, 64'd3);
    write_reg(CFG_PATTERN_LOW, 64'h0000_0000_0063_6261);
    write_reg(CFG_BASE_ADDRESS, 64'h0000_1000);
    send_word(8'h61, 1'b0);
    send_word(8'h62, 1'b0);
    send_word(8'h63, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h78, 1'b1);
    send_word(8'h61, 1'b0);
    send_word(8'h62, 1'b0);
    send_word(8'h63, 1'b0);
    send_word(8'h64, 1'b1);
    settle();

    for (int p = 0; p < 17; p++) begin
      new_setting();
      steady <= (p == 4 || p == 5);
      short_regions = (p == 9 || p == 13);
      if (p == 9) hold_request <= 1'b1;
      phase_bytes = 0;
      while (phase_bytes < 17) begin
        send_region(short_regions ? 0 : $urandom_range(6), $urandom_range(99) < 80,
                    $urandom_range(99) < 15, short_regions ? $urandom_range(1) :
                    $urandom_range(5), sent);
        phase_bytes += sent;
      end
      settle();
    end

    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
